FILE: design/sm4_pkg.sv
package sm4_pkg;

    localparam int ROUNDS     = 32;
    localparam int RND_W      = $clog2(ROUNDS);
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

    typedef logic [WORD_W-1:0] t_word;

    // system parameter fk
    localparam t_word FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // nonlinear byte substitution on a whole word
    function automatic t_word tau(input t_word a);
        tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    function automatic t_word rol(input t_word v, input int s);
        rol = (v << s) | (v >> (WORD_W - s));
    endfunction

    // linear transform of the data rounds
    function automatic t_word lin_data(input t_word b);
        lin_data = b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
    endfunction

    // linear transform of the key schedule
    function automatic t_word lin_key(input t_word b);
        lin_key = b ^ rol(b, 13) ^ rol(b, 23);
    endfunction

    // ck byte j of round i is (4*i + j) * 7 mod 256
    function automatic t_word ck_word(input logic [RND_W-1:0] idx);
        logic [7:0] base;
        t_word      w;
        base = {1'b0, idx, 2'b00};
        for (int j = 0; j < 4; j++) begin
            w[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
        end
        ck_word = w;
    endfunction

endpackage

FILE: design/sm4_if.sv
// block input channel
interface sm4_in_if
    import sm4_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] block_high;
    logic [HALF_W-1:0] block_low;
    logic              decrypt;

    modport source (output valid, output block_high, output block_low, output decrypt,
                    input ready);
    modport sink   (input valid, input block_high, input block_low, input decrypt,
                    output ready);
endinterface

// result output channel
interface sm4_out_if
    import sm4_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

// configuration write channel
interface sm4_cfg_if
    import sm4_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [HALF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/sm4_block_cipher_unit.sv
// channel   dir   payload                              transaction when
// i_cfg     in    index, data (key_high=0, key_low=1)  valid && ready
// i_blk     in    block_high, block_low, decrypt       valid && ready
// o_res     out   result_high, result_low              valid && ready
//
// a key write starts a schedule run on the shared round unit;
// no block and no further key write is taken meanwhile
// a block is loaded, then runs one round per cycle, bar the hold below, through
// the same round unit, with the round key read from a 32-entry memory
// a result waits in the output register; with a key loaded, a new block is taken meanwhile,
// and a finished block holds in its last round while that register is full
// reset is synchronous, active low; it clears the key and the key-ready flag
module sm4_block_cipher_unit
    import sm4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sm4_cfg_if.sink   i_cfg,
    sm4_in_if.sink    i_blk,
    sm4_out_if.source o_res
);

    typedef enum logic [1:0] {S_IDLE, S_KEXP, S_RUN} t_state_e;

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

    t_state_e          r_state;
    logic [RND_W-1:0]  r_cnt;
    logic              r_dec;
    logic              r_keys_ready;
    logic [HALF_W-1:0] r_key_hi;
    logic [HALF_W-1:0] r_key_lo;
    t_word             r_w [4];
    t_word             r_rk;
    t_word             r_rk_mem [ROUNDS];
    logic              r_out_valid;
    logic [HALF_W-1:0] r_res_hi;
    logic [HALF_W-1:0] r_res_lo;

    logic              out_free;
    logic              cfg_fire;
    logic              blk_fire;
    logic              advance;
    logic              rk_load;
    logic              res_load;
    logic [RND_W-1:0]  rd_addr;
    logic [RND_W-1:0]  nxt_rnd;
    logic [HALF_W-1:0] n_key_hi;
    logic [HALF_W-1:0] n_key_lo;
    t_word             rk_sel;
    t_word             mix;
    t_word             sub;
    t_word             nx;

    // handshakes
    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_blk.ready = (r_state == S_IDLE) && !i_cfg.valid && (r_keys_ready || out_free);
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign blk_fire    = i_blk.valid && i_blk.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.result_high = r_res_hi;
    assign o_res.result_low  = r_res_lo;

    // key after this write
    assign n_key_hi = (i_cfg.index == REG_KEY_HIGH) ? i_cfg.data : r_key_hi;
    assign n_key_lo = (i_cfg.index == REG_KEY_LOW)  ? i_cfg.data : r_key_lo;

    // shared round unit: key schedule or cipher round
    always_comb begin
        rk_sel = (r_state == S_KEXP) ? ck_word(r_cnt) : r_rk;
        mix    = r_w[1] ^ r_w[2] ^ r_w[3] ^ rk_sel;
        sub    = tau(mix);
        nx     = r_w[0] ^ ((r_state == S_KEXP) ? lin_key(sub) : lin_data(sub));
    end

    // round key fetch one round ahead
    always_comb begin
        advance = (r_state == S_RUN) && ((r_cnt != LAST_RND) || out_free);
        rk_load = (r_state == S_IDLE) || advance;
        nxt_rnd = r_cnt + RND_W'(1);
        if (r_state == S_IDLE) begin
            rd_addr = i_blk.decrypt ? LAST_RND : '0;
        end else begin
            rd_addr = r_dec ? ~nxt_rnd : nxt_rnd;
        end
    end

    // output register takes a zero result or a finished block
    assign res_load = (blk_fire && !r_keys_ready) || (advance && (r_cnt == LAST_RND));

    // round key memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_KEXP) begin
            r_rk_mem[r_cnt] <= nx;
        end
        if (rk_load) begin
            r_rk <= r_rk_mem[rd_addr];
        end
    end

    // sequencer, working words and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_key_hi     <= '0;
            r_key_lo     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_fire) begin
                        if (i_cfg.index == REG_KEY_HIGH || i_cfg.index == REG_KEY_LOW) begin
                            r_key_hi <= n_key_hi;
                            r_key_lo <= n_key_lo;
                            r_w[0]   <= n_key_hi[63:32] ^ FK[0];
                            r_w[1]   <= n_key_hi[31:0]  ^ FK[1];
                            r_w[2]   <= n_key_lo[63:32] ^ FK[2];
                            r_w[3]   <= n_key_lo[31:0]  ^ FK[3];
                            r_cnt    <= '0;
                            r_state  <= S_KEXP;
                        end
                    end else if (blk_fire) begin
                        if (r_keys_ready) begin
                            r_w[0]  <= i_blk.block_high[63:32];
                            r_w[1]  <= i_blk.block_high[31:0];
                            r_w[2]  <= i_blk.block_low[63:32];
                            r_w[3]  <= i_blk.block_low[31:0];
                            r_dec   <= i_blk.decrypt;
                            r_cnt   <= '0;
                            r_state <= S_RUN;
                        end else begin
                            // no key yet: the result is all zero
                            r_res_hi <= '0;
                            r_res_lo <= '0;
                        end
                    end
                end
                S_KEXP: begin
                    r_w[0] <= r_w[1];
                    r_w[1] <= r_w[2];
                    r_w[2] <= r_w[3];
                    r_w[3] <= nx;
                    r_cnt  <= nxt_rnd;
                    if (r_cnt == LAST_RND) begin
                        r_keys_ready <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_RUN: begin
                    if (advance) begin
                        r_w[0] <= r_w[1];
                        r_w[1] <= r_w[2];
                        r_w[2] <= r_w[3];
                        r_w[3] <= nx;
                        r_cnt  <= nxt_rnd;
                        if (r_cnt == LAST_RND) begin
                            // final word reversal
                            r_res_hi <= {nx, r_w[3]};
                            r_res_lo <= {r_w[2], r_w[1]};
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // last schedule round leaves the keys marked ready
    a_kexp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEXP && r_cnt == LAST_RND) |=> (r_keys_ready && r_state == S_IDLE))
        else $error("key schedule did not finish");

    // a keyed block starts its rounds at round zero
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (blk_fire && r_keys_ready) |=> (r_state == S_RUN && r_cnt == '0))
        else $error("cipher run did not start");

    // cipher rounds run only on an expanded key
    a_run_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_keys_ready)
        else $error("cipher run without keys");

    // a full output register holds the last round
    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == LAST_RND && r_out_valid && !o_res.ready)
        |=> (r_state == S_RUN && r_cnt == LAST_RND))
        else $error("last round lost while output full");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import sm4_pkg::*;

    localparam int NUM_ROUNDS  = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYC  = 40;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_HI = '1;

    // direction codes
    localparam logic DIR_ENC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

    localparam logic [31:0] SYS_FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197,
                                           32'hb27022dc};

    localparam logic [7:0] SUB_BOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7, 8'h16, 8'hb6, 8'h14, 8'hc2,
        8'h28, 8'hfb, 8'h2c, 8'h05, 8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9c, 8'h42, 8'h50, 8'hf4,
        8'h91, 8'hef, 8'h98, 8'h7a, 8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95, 8'h80, 8'hdf, 8'h94, 8'hfa,
        8'h75, 8'h8f, 8'h3f, 8'ha6, 8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8, 8'h68, 8'h6b, 8'h81, 8'hb2,
        8'h71, 8'h64, 8'hda, 8'h8b, 8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2, 8'h25, 8'h22, 8'h7c, 8'h3b,
        8'h01, 8'h21, 8'h78, 8'h87, 8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e, 8'hea, 8'hbf, 8'h8a, 8'hd2,
        8'h40, 8'hc7, 8'h38, 8'hb5, 8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55, 8'had, 8'h93, 8'h32, 8'h30,
        8'hf5, 8'h8c, 8'hb1, 8'he3, 8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f, 8'hd5, 8'hdb, 8'h37, 8'h45,
        8'hde, 8'hfd, 8'h8e, 8'h2f, 8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f, 8'h11, 8'hd9, 8'h5c, 8'h41,
        8'h1f, 8'h10, 8'h5a, 8'hd8, 8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0, 8'h89, 8'h69, 8'h97, 8'h4a,
        8'h0c, 8'h96, 8'h77, 8'h7e, 8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20, 8'h79, 8'hee, 8'h5f, 8'h3e,
        8'hd7, 8'hcb, 8'h39, 8'h48
    };

    typedef struct packed {
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } cipher_blk_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sm4_cfg_if cfg_ch ();
    sm4_in_if  blk_ch ();
    sm4_out_if res_ch ();

    sm4_block_cipher_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_blk   (blk_ch),
        .o_res   (res_ch)
    );

    // predictor state: key registers and expanded round keys
    logic [HALF_W-1:0] key_hi_reg  = '0;
    logic [HALF_W-1:0] key_lo_reg  = '0;
    logic [31:0]       rk_tab [NUM_ROUNDS];
    logic              keys_loaded = 1'b0;

    cipher_blk_t pending_results [$];
    cipher_blk_t front_blk;
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          hold_req     = 0;
    int          hold_left    = 0;

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] a);
        return {SUB_BOX[a[31:24]], SUB_BOX[a[23:16]], SUB_BOX[a[15:8]], SUB_BOX[a[7:0]]};
    endfunction

    function automatic logic [31:0] data_mix(input logic [31:0] b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] key_mix(input logic [31:0] b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // schedule constant: byte j of round r is (4r + j) * 7 mod 256
    function automatic logic [31:0] ck_const(input int r);
        logic [31:0] c;
        for (int j = 0; j < 4; j++) begin
            c[31-8*j -: 8] = 8'((4 * r + j) * 7);
        end
        return c;
    endfunction

    // key schedule from the current key registers
    function automatic void expand_round_keys();
        logic [31:0] w [4];
        logic [31:0] nk;
        w[0] = key_hi_reg[63:32] ^ SYS_FK[0];
        w[1] = key_hi_reg[31:0]  ^ SYS_FK[1];
        w[2] = key_lo_reg[63:32] ^ SYS_FK[2];
        w[3] = key_lo_reg[31:0]  ^ SYS_FK[3];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            nk = w[0] ^ key_mix(sub_word(w[1] ^ w[2] ^ w[3] ^ ck_const(r)));
            rk_tab[r] = nk;
            w[0] = w[1];
            w[1] = w[2];
            w[2] = w[3];
            w[3] = nk;
        end
        keys_loaded = 1'b1;
    endfunction

    // 32 rounds then word reversal; zero while no key has been loaded
    function automatic cipher_blk_t sm4_crypt(input logic [HALF_W-1:0] hi,
                                              input logic [HALF_W-1:0] lo, input logic dir);
        logic [31:0] x [4];
        logic [31:0] rk;
        logic [31:0] nx;
        cipher_blk_t res;
        if (!keys_loaded) begin
            return '0;
        end
        x[0] = hi[63:32];
        x[1] = hi[31:0];
        x[2] = lo[63:32];
        x[3] = lo[31:0];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            rk = (dir == DIR_DEC) ? rk_tab[NUM_ROUNDS-1-r] : rk_tab[r];
            nx = x[0] ^ data_mix(sub_word(x[1] ^ x[2] ^ x[3] ^ rk));
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        res.hi = {x[3], x[2]};
        res.lo = {x[1], x[0]};
        return res;
    endfunction

    function automatic logic [HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one block, with a random gap first, and record its expected result
    task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                              input logic dir);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            blk_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        blk_ch.valid      <= 1'b1;
        blk_ch.block_high <= hi;
        blk_ch.block_low  <= lo;
        blk_ch.decrypt    <= dir;
        do @(posedge i_clk); while (!blk_ch.ready);
        pending_results.push_back(sm4_crypt(hi, lo, dir));
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_results();
        @(negedge i_clk);
        blk_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // one register write transaction, only once the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_KEY_HIGH: begin
                key_hi_reg = value;
                expand_round_keys();
            end
            REG_KEY_LOW: begin
                key_lo_reg = value;
                expand_round_keys();
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // blocks before any key load, and writes to undecoded indexes
    task automatic test_no_key();
        send_block('0, '0, DIR_ENC);
        send_block('1, '1, DIR_DEC);
        send_block({16{4'h5}}, {16{4'ha}}, DIR_ENC);
        send_block({16{4'ha}}, {16{4'h5}}, DIR_DEC);
        cfg_write(UNUSED_INDEX_LO, '1);
        cfg_write(UNUSED_INDEX_HI, rand64());
        send_block(rand64(), rand64(), DIR_ENC);
        send_block(rand64(), rand64(), DIR_DEC);
    endtask

    // one key half at a time, the other keeps its old value
    task automatic test_partial_key();
        cfg_write(REG_KEY_HIGH, '1);
        send_block(rand64(), rand64(), DIR_ENC);
        send_block(rand64(), rand64(), DIR_DEC);
        cfg_write(REG_KEY_LOW, '1);
        send_block('0, '1, DIR_ENC);
        send_block('1, '0, DIR_DEC);
    endtask

    // standard test key and block, plus block extremes in both directions
    task automatic test_known_vector();
        cfg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
        cfg_write(REG_KEY_LOW, 64'hfedcba9876543210);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, DIR_ENC);
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, DIR_DEC);
        send_block('0, '0, DIR_ENC);
        send_block('0, '0, DIR_DEC);
        send_block('1, '1, DIR_ENC);
        send_block('1, '1, DIR_DEC);
    endtask

    // long receiver hold-off while blocks keep coming, then a full pause
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 300;
        for (int i = 0; i < 8; i++) begin
            send_block(rand64(), rand64(), 1'($urandom_range(0, 1)));
        end
        drain_results();
    endtask

    // random keys and blocks under one idle setting
    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int n_items);
        cipher_blk_t ct;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        int sent;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < 4; k++) begin
            // new key: full, either half alone, or an extreme
            case ($urandom_range(0, 3))
                0: begin
                    cfg_write(REG_KEY_HIGH, rand64());
                    cfg_write(REG_KEY_LOW, rand64());
                end
                1: cfg_write(REG_KEY_HIGH, rand64());
                2: cfg_write(REG_KEY_LOW, rand64());
                default: begin
                    cfg_write(REG_KEY_HIGH, $urandom_range(0, 1) ? '1 : '0);
                    cfg_write(REG_KEY_LOW, $urandom_range(0, 1) ? '1 : '0);
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CFG_IDX_W'($urandom_range(2, 255)), rand64());
            end
            sent = 0;
            while (sent < n_items / 4) begin
                hi = rand64();
                lo = rand64();
                if ($urandom_range(0, 9) < 3) begin
                    // round trip: encrypt, then decrypt the ciphertext
                    ct = sm4_crypt(hi, lo, DIR_ENC);
                    send_block(hi, lo, DIR_ENC);
                    send_block(ct.hi, ct.lo, DIR_DEC);
                    sent += 2;
                end else begin
                    send_block(hi, lo, 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    // receiver: random ready, with an occasional long hold-off
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h %h", $time,
                         res_ch.result_high, res_ch.result_low);
                error_count++;
            end else begin
                front_blk = pending_results.pop_front();
                if (res_ch.result_high !== front_blk.hi) begin
                    $display("%0t: result_high expected %h actual %h", $time,
                             front_blk.hi, res_ch.result_high);
                    error_count++;
                end
                if (res_ch.result_low !== front_blk.lo) begin
                    $display("%0t: result_low expected %h actual %h", $time,
                             front_blk.lo, res_ch.result_low);
                    error_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n           = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        blk_ch.valid      = 1'b0;
        blk_ch.block_high = '0;
        blk_ch.block_low  = '0;
        blk_ch.decrypt    = DIR_ENC;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_no_key();
        test_partial_key();
        test_known_vector();
        test_backpressure();
        test_random_traffic(34, 81, 264);
        test_random_traffic(81, 34, 264);
        test_random_traffic(0, 0, 264);
        drain_results();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
